>>> hdl/disc_dilate_erode_mask_assert.svh
// ----------------------------------------------------------------------------
// disc_dilate_erode_mask_assert.svh
// assertion macros for the disc morphology block
// ----------------------------------------------------------------------------
`ifndef DISC_DILATE_ERODE_MASK_ASSERT_SVH
`define DISC_DILATE_ERODE_MASK_ASSERT_SVH

`ifndef SYNTHESIS
// property checked every clock outside reset
`define DDEM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// consequence checked in the cycle after the trigger
`define DDEM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DDEM_ASSERT(lbl, prop, msg)
`define DDEM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/ddem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddem_pkg
// shared types, register indexes and disc membership function
// ----------------------------------------------------------------------------
package ddem_pkg;

    localparam int RAD_W  = 5;   // holds radius up to 31
    localparam int GEOM_W = 14;  // holds sizes up to 16383

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DISC_RADIUS  = 2'd2;
    localparam logic [1:0] REG_MORPH_MODE   = 2'd3;

    localparam logic [7:0] PIX_ON  = 8'd255;
    localparam logic [7:0] PIX_OFF = 8'd0;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_value;
        logic       frame_last;
    } t_out_item;

    // geometry of the result pixel at the window center
    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic              shrink;
        logic [GEOM_W-1:0] width;
        logic [GEOM_W-1:0] height;
        logic [GEOM_W-1:0] ox;
        logic [GEOM_W-1:0] oy;
    } t_geom;

    function automatic logic disc_in(input logic [RAD_W-1:0] rad, input int j, input int k);
        int dx;
        int dy;
        int rr;
        rr = int'(rad);
        dx = rr - j;
        dy = rr - k;
        return (dx * dx + dy * dy) <= rr * rr;
    endfunction

endpackage

>>> hdl/ddem_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddem_line_store
// column memory of pixel flags for the rows above, with write-back bypass
// ----------------------------------------------------------------------------
module ddem_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int LW    = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_rd,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr,
    input  logic          i_flag,
    output logic [LW:0]   o_col
);
    logic [LW-1:0] r_mem [DEPTH];
    logic [LW-1:0] r_q;
    logic [AW-1:0] r_addr;
    logic          r_byp;
    logic [LW-1:0] r_byp_data;
    logic [LW-1:0] cur;
    logic [LW-1:0] wr_data;

    assign cur     = r_byp ? r_byp_data : r_q;
    // rows age by one, newest flag enters at the bottom
    assign wr_data = {cur[LW-2:0], i_flag};
    assign o_col   = {cur, i_flag};

    always_ff @(posedge i_clk) begin
        if (i_en && i_wr) begin
            r_mem[r_addr] <= wr_data;
        end
        if (i_en && i_rd) begin
            r_q        <= r_mem[i_rd_addr];
            r_addr     <= i_rd_addr;
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_en && i_rd) begin
            r_byp <= i_wr && (r_addr == i_rd_addr);
        end
    end
endmodule

>>> hdl/ddem_disc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddem_disc_window
// square window of flag columns and the disc grow / shrink decision
// ----------------------------------------------------------------------------
module ddem_disc_window #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [2*MAX_RADIUS:0]     i_col,
    input  ddem_pkg::t_geom           i_geom,
    output logic                      o_hit
);
    import ddem_pkg::*;

    localparam int N = 2 * MAX_RADIUS + 1;

    logic [N-1:0] r_win [N];
    logic [N-1:0] col_ok;
    logic [N-1:0] row_ok;
    logic [N*N-1:0] sel;
    logic [N*N-1:0] bits;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= i_col;
            for (int j = 1; j < N; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    // column j is dx = r - j, row k is dy = r - k
    for (genvar j = 0; j < N; j++) begin : g_bound
        logic signed [GEOM_W+1:0] xx;
        logic signed [GEOM_W+1:0] yy;
        assign xx = $signed({2'b00, i_geom.ox}) + $signed((GEOM_W+2)'(i_geom.radius))
                    - $signed((GEOM_W+2)'(j));
        assign yy = $signed({2'b00, i_geom.oy}) + $signed((GEOM_W+2)'(i_geom.radius))
                    - $signed((GEOM_W+2)'(j));
        assign col_ok[j] = (xx >= 0) && (xx < $signed({2'b00, i_geom.width}));
        assign row_ok[j] = (yy >= 0) && (yy < $signed({2'b00, i_geom.height}));
    end

    for (genvar j = 0; j < N; j++) begin : g_col
        for (genvar k = 0; k < N; k++) begin : g_row
            assign sel[j*N+k]  = disc_in(i_geom.radius, j, k) && col_ok[j] && row_ok[k];
            assign bits[j*N+k] = r_win[j][k];
        end
    end

    assign o_hit = i_geom.shrink ? (&(~sel | bits)) : (|(sel & bits));
endmodule

>>> hdl/disc_dilate_erode_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_dilate_erode_mask
// binary disc dilate / erode of a raster mask; without output stall, one pixel per clock
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  input    | i_in_valid   | o_in_ready   | i_in_data  (pixel_value, flush)
//  output   | o_out_valid  | i_out_ready  | o_out_data (out_value, frame_last)
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one item per clock unless stalled; results pass stages a, b and output register
//  results lag their pixel by radius rows plus radius pixels, flush items drain them
//  the column memory takes one read and one write per clock, a bypass covers width 1
//  the whole pipeline holds while a result waits on the output
//  reset clears counters and valids and loads default config, no memory clearing pass
// ----------------------------------------------------------------------------
module disc_dilate_erode_mask #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ddem_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ddem_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data
);
    import ddem_pkg::*;

    `include "disc_dilate_erode_mask_assert.svh"

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int LW = 2 * MAX_RADIUS;

    // configuration
    logic [10:0] r_cfg_width,  n_cfg_width;
    logic [10:0] r_cfg_height, n_cfg_height;
    logic [2:0]  r_cfg_radius, n_cfg_radius;
    logic        r_cfg_mode,   n_cfg_mode;
    logic [31:0] w32, h32, rad32;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [RW-1:0] r_radius;
    logic [PW-1:0] r_total;
    logic [PW-1:0] r_delay;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg_width  = r_cfg_width;
        n_cfg_height = r_cfg_height;
        n_cfg_radius = r_cfg_radius;
        n_cfg_mode   = r_cfg_mode;
        if (!i_rst_n) begin
            n_cfg_width  = 11'd1024;
            n_cfg_height = 11'd1024;
            n_cfg_radius = 3'd1;
            n_cfg_mode   = 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  n_cfg_width  = i_cfg_data;
                REG_IMAGE_HEIGHT: n_cfg_height = i_cfg_data;
                REG_DISC_RADIUS:  n_cfg_radius = i_cfg_data[2:0];
                REG_MORPH_MODE:   n_cfg_mode   = i_cfg_data[0];
                default: ;
            endcase
        end
        w32 = 32'(n_cfg_width);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        h32 = 32'(n_cfg_height);
        if (h32 == 32'd0) begin
            h32 = 32'd1;
        end else if (h32 > 32'(MAX_HEIGHT)) begin
            h32 = 32'(MAX_HEIGHT);
        end
        rad32 = 32'(n_cfg_radius);
        if (rad32 > 32'(MAX_RADIUS)) begin
            rad32 = 32'(MAX_RADIUS);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg_width  <= n_cfg_width;
        r_cfg_height <= n_cfg_height;
        r_cfg_radius <= n_cfg_radius;
        r_cfg_mode   <= n_cfg_mode;
        r_width      <= WW'(w32);
        r_height     <= HW'(h32);
        r_radius     <= RW'(rad32);
        r_total      <= PW'(WW'(w32)) * PW'(HW'(h32));
        r_delay      <= PW'(RW'(rad32)) * PW'(WW'(w32)) + PW'(RW'(rad32));
    end

    // input side
    logic en, acc, adv, emit, last, flag;
    logic [PW-1:0] r_in_pos, r_out_pos;
    logic [XW-1:0] r_in_x, r_out_x;
    logic [YW-1:0] r_out_y;

    assign en   = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign acc  = i_in_valid && en;
    assign adv  = acc && (!i_in_data.flush || (r_in_pos >= r_total));
    assign emit = adv && (r_in_pos >= r_delay);
    assign last = emit && ((r_out_pos + PW'(1)) == r_total);
    assign flag = (r_in_pos < r_total) && (i_in_data.pixel_value != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_in_x    <= '0;
            r_out_x   <= '0;
            r_out_y   <= '0;
        end else if (last) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_in_x    <= '0;
            r_out_x   <= '0;
            r_out_y   <= '0;
        end else if (adv) begin
            r_in_pos <= r_in_pos + PW'(1);
            r_in_x   <= (r_in_x == XW'(r_width - WW'(1))) ? '0 : r_in_x + XW'(1);
            if (emit) begin
                r_out_pos <= r_out_pos + PW'(1);
                if (r_out_x == XW'(r_width - WW'(1))) begin
                    r_out_x <= '0;
                    r_out_y <= r_out_y + YW'(1);
                end else begin
                    r_out_x <= r_out_x + XW'(1);
                end
            end
        end
    end

    // stage a: column read in flight
    logic          r_a_valid, r_a_emit;
    logic          r_a_last, r_a_flag;
    logic [7:0]    r_a_pix;
    logic [XW-1:0] r_a_ox;
    logic [YW-1:0] r_a_oy;
    // stage b: window shifted
    logic          r_b_emit;
    logic          r_b_last;
    logic [7:0]    r_b_pix;
    logic [XW-1:0] r_b_ox;
    logic [YW-1:0] r_b_oy;
    // output register
    logic          r_out_valid;
    t_out_item     r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_a_emit    <= 1'b0;
            r_b_emit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= adv;
            r_a_emit    <= emit;
            r_b_emit    <= r_a_valid && r_a_emit;
            r_out_valid <= r_b_emit;
        end
    end

    logic [LW:0] col;
    logic        hit;
    t_geom       geom;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_last <= last;
            r_a_flag <= flag;
            r_a_pix  <= i_in_data.pixel_value;
            r_a_ox   <= r_out_x;
            r_a_oy   <= r_out_y;
            r_b_last <= r_a_last;
            r_b_pix  <= r_a_pix;
            r_b_ox   <= r_a_ox;
            r_b_oy   <= r_a_oy;
            r_out_data.out_value  <= (r_radius == '0) ? r_b_pix : (hit ? PIX_ON : PIX_OFF);
            r_out_data.frame_last <= r_b_last;
        end
    end

    ddem_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW),
        .LW    (LW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_rd      (adv),
        .i_rd_addr (r_in_x),
        .i_wr      (r_a_valid),
        .i_flag    (r_a_flag),
        .o_col     (col)
    );

    assign geom.radius = RAD_W'(r_radius);
    assign geom.shrink = r_cfg_mode;
    assign geom.width  = GEOM_W'(r_width);
    assign geom.height = GEOM_W'(r_height);
    assign geom.ox     = GEOM_W'(r_b_ox);
    assign geom.oy     = GEOM_W'(r_b_oy);

    ddem_disc_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_disc_window (
        .i_clk   (i_clk),
        .i_shift (en && r_a_valid),
        .i_col   (col),
        .i_geom  (geom),
        .o_hit   (hit)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `DDEM_ASSERT(a_out_x_range, WW'(r_out_x) < r_width, "output column beyond width")
    `DDEM_ASSERT(a_out_y_range, HW'(r_out_y) < r_height, "output row beyond height")
    `DDEM_ASSERT_NEXT(a_frame_wrap, last, (r_in_pos == '0) && (r_out_pos == '0), "no wrap")
endmodule
